@@ rtl/core/attitude_filter_lqr_mixer_core_defines.svh @@
// Assertion macros shared by the core RTL.
`ifndef ATTITUDE_FILTER_LQR_MIXER_CORE_DEFINES_SVH
`define ATTITUDE_FILTER_LQR_MIXER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define ALM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ALM_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ALM_ASSERT(lbl, clk, rstn, prop)
`define ALM_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

@@ rtl/core/alm_pkg.sv @@
package alm_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQY,
    S_SQZ,
    S_SQRT,
    S_CORD,
    S_CDONE,
    S_INC,
    S_BLEND,
    S_LQR,
    S_SUM,
    S_CMD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic               ld;
    logic signed [55:0] a;
    logic        [23:0] b;
    logic        [4:0]  n;
  } mul_ld_t;

  typedef struct packed {
    logic signed [39:0] x;
    logic signed [39:0] y;
    logic signed [32:0] z;
    logic               zero;
  } cord_t;

  localparam logic [1:0] REG_BLEND_GAIN = 2'd0;
  localparam logic [1:0] REG_GYRO_SCALE = 2'd1;
  localparam logic [1:0] REG_OUT_GAIN   = 2'd2;

  localparam logic [15:0] RST_BLEND_GAIN = 16'd62259;
  localparam logic [23:0] RST_GYRO_SCALE = 24'd29985;
  localparam logic [9:0]  RST_OUT_GAIN   = 10'd200;

  localparam logic signed [32:0] PI_Q = 33'sd843314857;

  // Bit m set: the term enters motor m with a negative sign.
  localparam logic [3:0] ROLL_NEG  = 4'b0011;
  localparam logic [3:0] PITCH_NEG = 4'b1001;
  localparam logic [3:0] YAW_NEG   = 4'b0101;

  function automatic logic signed [32:0] atan_tab(input logic [4:0] i);
    case (i)
      5'd0:    return 33'sd210828714;
      5'd1:    return 33'sd124459457;
      5'd2:    return 33'sd65760959;
      5'd3:    return 33'sd33381290;
      5'd4:    return 33'sd16755422;
      5'd5:    return 33'sd8385880;
      5'd6:    return 33'sd4193963;
      5'd7:    return 33'sd2097109;
      5'd8:    return 33'sd1048571;
      5'd9:    return 33'sd524287;
      5'd10:   return 33'sd262144;
      5'd11:   return 33'sd131072;
      5'd12:   return 33'sd65536;
      5'd13:   return 33'sd32768;
      5'd14:   return 33'sd16384;
      5'd15:   return 33'sd8192;
      5'd16:   return 33'sd4096;
      5'd17:   return 33'sd2048;
      5'd18:   return 33'sd1024;
      5'd19:   return 33'sd512;
      5'd20:   return 33'sd256;
      5'd21:   return 33'sd128;
      5'd22:   return 33'sd64;
      5'd23:   return 33'sd32;
      5'd24:   return 33'sd16;
      5'd25:   return 33'sd8;
      5'd26:   return 33'sd4;
      5'd27:   return 33'sd2;
      5'd28:   return 33'sd1;
      default: return 33'sd0;
    endcase
  endfunction

  // Magnitudes of the LQR gains, Q2.12, in the order roll, roll rate,
  // pitch, pitch rate, yaw rate.
  function automatic logic [13:0] lqr_mag(input logic [2:0] k);
    case (k)
      3'd0:    return 14'd14835;
      3'd1:    return 14'd3396;
      3'd2:    return 14'd14467;
      3'd3:    return 14'd3308;
      3'd4:    return 14'd2010;
      default: return 14'd0;
    endcase
  endfunction

  function automatic logic signed [55:0] lqr_opnd(input logic [2:0] k,
                                                  input logic signed [31:0] roll,
                                                  input logic signed [31:0] pitch,
                                                  input logic signed [15:0] rx,
                                                  input logic signed [15:0] ry,
                                                  input logic signed [15:0] rz);
    case (k)
      3'd0:    return 56'(roll);
      3'd1:    return 56'(rx);
      3'd2:    return 56'(pitch);
      3'd3:    return 56'(ry);
      3'd4:    return 56'(rz);
      default: return 56'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
    if (v > 56'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -56'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Prepares the vectoring pass: scaling, rotation by pi for a negative x,
  // and the result for a zero y, which needs no iterations.
  function automatic cord_t cord_init(input logic signed [27:0] y,
                                      input logic signed [27:0] x);
    cord_t c;
    logic signed [39:0] xs;
    logic signed [39:0] ys;
    xs = 40'(x);
    ys = 40'(y);
    xs = xs <<< 8;
    ys = ys <<< 8;
    c.zero = (y == 28'sd0);
    c.z = 33'sd0;
    c.x = xs;
    c.y = ys;
    if (c.zero) begin
      c.z = (x < 28'sd0) ? PI_Q : 33'sd0;
    end else if (x < 28'sd0) begin
      c.z = (y > 28'sd0) ? PI_Q : -PI_Q;
      c.x = -xs;
      c.y = -ys;
    end
    return c;
  endfunction

endpackage

@@ rtl/core/attitude_filter_lqr_mixer_core.sv @@
// Channel      Dir  Bits  Beat content
// s_axis       in   96    accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
// m_axis       out  192   four motor commands, roll_angle, pitch_angle
// cfg          in   24    blend_gain, gyro_step_scale, output_gain
// Per sample the core runs a square root, two CORDIC passes and a chain of products.
// The shared shift-add multiplier, one operand bit per cycle, computes every product;
// the square root works bit-serially and each CORDIC pass runs CORDIC_STEPS iterations.
// A CORDIC pass whose y input is zero skips its iterations.
// Reset clears both estimates and loads the register defaults.
// A new sample is taken while the previous result still waits on m_axis.
`include "attitude_filter_lqr_mixer_core_defines.svh"

module attitude_filter_lqr_mixer_core #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // motor_front_left, motor_front_right, motor_rear_right, motor_rear_left,
  // roll_angle, pitch_angle
  output logic [191:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i
);
  import alm_pkg::*;

  localparam int CI_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [CI_W-1:0] CI_LAST = CI_W'(CORDIC_STEPS - 1);

  state_e state_q, state_d;
  logic [2:0] sub_q, sub_d;
  logic ph_q, ph_d;
  logic m_tvalid_q, m_tvalid_d;
  logic [15:0] g_q, g_d;
  logic [23:0] gss_q, gss_d;
  logic [9:0] og_q, og_d;
  logic signed [31:0] roll_q, roll_d, pitch_q, pitch_d;

  logic signed [15:0] ax_q, ax_d, ay_q, ay_d, az_q, az_d;
  logic signed [15:0] rx_q, rx_d, ry_q, ry_d, rz_q, rz_d;
  logic [30:0] sq_q, sq_d;
  logic [51:0] sv_q, sv_d, sr_q, sr_d, sb_q, sb_d;
  logic signed [39:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [32:0] cz_q, cz_d;
  logic zero_q, zero_d;
  logic [CI_W-1:0] cit_q, cit_d;
  logic signed [31:0] accr_q, accr_d, accp_q, accp_d;
  logic signed [47:0] p_q [5];
  logic signed [47:0] p_d [5];
  logic signed [31:0] mot_q [4];
  logic signed [31:0] mot_d [4];
  logic [191:0] od_q, od_d;

  mul_ld_t mul_ld;
  logic signed [55:0] ma_q, ma_d, macc_q, macc_d;
  logic [23:0] mb_q, mb_d;
  logic [4:0] mcnt_q, mcnt_d;
  logic mul_idle;

  assign mul_idle = (mcnt_q == 5'd0);
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata = od_q;

  always_comb begin
    g_d = g_q;
    gss_d = gss_q;
    og_d = og_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BLEND_GAIN: g_d = cfg_data_i[15:0];
        REG_GYRO_SCALE: gss_d = cfg_data_i;
        REG_OUT_GAIN:   og_d = cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ma_d = ma_q;
    mb_d = mb_q;
    mcnt_d = mcnt_q;
    macc_d = macc_q;
    if (mul_ld.ld) begin
      ma_d = mul_ld.a;
      mb_d = mul_ld.b;
      mcnt_d = mul_ld.n;
      macc_d = 56'sd0;
    end else if (!mul_idle) begin
      if (mb_q[0]) begin
        macc_d = macc_q + ma_q;
      end
      ma_d = ma_q <<< 1;
      mb_d = mb_q >> 1;
      mcnt_d = mcnt_q - 5'd1;
    end
  end

  always_comb begin
    logic [16:0] absv;
    logic [32:0] sqsum;
    logic [51:0] trial;
    logic signed [39:0] xsh, ysh;
    logic signed [27:0] py;
    logic signed [31:0] est, acc, res, cmd;
    logic signed [35:0] incv, diff;
    logic signed [55:0] tmp, grp_r, grp_p, grp_y, sum;
    logic [2:0] nxt;
    cord_t ci;
    absv = '0;
    sqsum = '0;
    trial = '0;
    xsh = '0;
    ysh = '0;
    py = '0;
    est = sub_q[0] ? pitch_q : roll_q;
    acc = sub_q[0] ? accp_q : accr_q;
    res = '0;
    cmd = '0;
    incv = '0;
    diff = '0;
    tmp = '0;
    grp_r = '0;
    grp_p = '0;
    grp_y = '0;
    sum = '0;
    nxt = sub_q + 3'd1;
    ci = '0;

    state_d = state_q;
    sub_d = sub_q;
    ph_d = ph_q;
    m_tvalid_d = m_tvalid_q & ~m_axis_tready;
    roll_d = roll_q;
    pitch_d = pitch_q;
    ax_d = ax_q;
    ay_d = ay_q;
    az_d = az_q;
    rx_d = rx_q;
    ry_d = ry_q;
    rz_d = rz_q;
    sq_d = sq_q;
    sv_d = sv_q;
    sr_d = sr_q;
    sb_d = sb_q;
    cx_d = cx_q;
    cy_d = cy_q;
    cz_d = cz_q;
    zero_d = zero_q;
    cit_d = cit_q;
    accr_d = accr_q;
    accp_d = accp_q;
    p_d = p_q;
    mot_d = mot_q;
    od_d = od_q;
    mul_ld = '0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          ax_d = s_axis_tdata[15:0];
          ay_d = s_axis_tdata[31:16];
          az_d = s_axis_tdata[47:32];
          rx_d = s_axis_tdata[63:48];
          ry_d = s_axis_tdata[79:64];
          rz_d = s_axis_tdata[95:80];
          absv = s_axis_tdata[31] ? 17'(-{1'b1, s_axis_tdata[31:16]})
                                  : {1'b0, s_axis_tdata[31:16]};
          mul_ld = '{ld: 1'b1, a: 56'(absv), b: 24'(absv), n: 5'd16};
          state_d = S_SQY;
        end
      end
      S_SQY: begin
        if (mul_idle) begin
          sq_d = macc_q[30:0];
          absv = az_q[15] ? 17'(-{1'b1, az_q}) : {1'b0, az_q};
          mul_ld = '{ld: 1'b1, a: 56'(absv), b: 24'(absv), n: 5'd16};
          state_d = S_SQZ;
        end
      end
      S_SQZ: begin
        if (mul_idle) begin
          sqsum = 33'(sq_q) + 33'(macc_q[31:0]);
          sv_d = {sqsum[31:0], 20'd0};
          sr_d = '0;
          sb_d = 52'h4000000000000;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sb_q != 52'd0) begin
          trial = sr_q + sb_q;
          if (sv_q >= trial) begin
            sv_d = sv_q - trial;
            sr_d = (sr_q >> 1) + sb_q;
          end else begin
            sr_d = sr_q >> 1;
          end
          sb_d = sb_q >> 2;
        end else begin
          ci = cord_init({{2{ay_q[15]}}, ay_q, 10'd0}, {{2{az_q[15]}}, az_q, 10'd0});
          cx_d = ci.x;
          cy_d = ci.y;
          cz_d = ci.z;
          zero_d = ci.zero;
          cit_d = '0;
          ph_d = 1'b0;
          state_d = S_CORD;
        end
      end
      S_CORD: begin
        if (!zero_q) begin
          xsh = cx_q >>> cit_q;
          ysh = cy_q >>> cit_q;
          if (cy_q > 40'sd0) begin
            cx_d = cx_q + ysh;
            cy_d = cy_q - xsh;
            cz_d = cz_q + atan_tab(5'(cit_q));
          end else begin
            cx_d = cx_q - ysh;
            cy_d = cy_q + xsh;
            cz_d = cz_q - atan_tab(5'(cit_q));
          end
        end
        cit_d = cit_q + 1'b1;
        if (zero_q || (cit_q == CI_LAST)) begin
          state_d = S_CDONE;
        end
      end
      S_CDONE: begin
        if (!ph_q) begin
          accr_d = sat32(56'(cz_q));
          py = -{{2{ax_q[15]}}, ax_q, 10'd0};
          ci = cord_init(py, {2'b00, sr_q[25:0]});
          cx_d = ci.x;
          cy_d = ci.y;
          cz_d = ci.z;
          zero_d = ci.zero;
          cit_d = '0;
          ph_d = 1'b1;
          state_d = S_CORD;
        end else begin
          accp_d = sat32(56'(cz_q));
          sub_d = 3'd0;
          mul_ld = '{ld: 1'b1, a: 56'(rx_q), b: gss_q, n: 5'd24};
          state_d = S_INC;
        end
      end
      S_INC: begin
        if (mul_idle) begin
          tmp = (macc_q + 56'sd2048) >>> 12;
          incv = 36'(tmp);
          diff = 36'(est) + incv - 36'(acc);
          mul_ld = '{ld: 1'b1, a: 56'(diff), b: {8'd0, g_q}, n: 5'd16};
          state_d = S_BLEND;
        end
      end
      S_BLEND: begin
        if (mul_idle) begin
          tmp = (56'(acc) <<< 16) + macc_q + 56'sd32768;
          res = sat32(tmp >>> 16);
          if (!sub_q[0]) begin
            roll_d = res;
            sub_d = 3'd1;
            mul_ld = '{ld: 1'b1, a: 56'(ry_q), b: gss_q, n: 5'd24};
            state_d = S_INC;
          end else begin
            pitch_d = res;
            sub_d = 3'd0;
            mul_ld = '{ld: 1'b1, a: lqr_opnd(3'd0, roll_q, res, rx_q, ry_q, rz_q),
                       b: 24'(lqr_mag(3'd0)), n: 5'd14};
            state_d = S_LQR;
          end
        end
      end
      S_LQR: begin
        if (mul_idle) begin
          p_d[sub_q] = macc_q[47:0];
          if (sub_q != 3'd4) begin
            sub_d = nxt;
            mul_ld = '{ld: 1'b1, a: lqr_opnd(nxt, roll_q, pitch_q, rx_q, ry_q, rz_q),
                       b: 24'(lqr_mag(nxt)), n: 5'd14};
          end else begin
            sub_d = 3'd0;
            state_d = S_SUM;
          end
        end
      end
      S_SUM: begin
        grp_r = 56'(p_q[0]) + (56'(p_q[1]) <<< 24);
        grp_p = 56'(p_q[2]) + (56'(p_q[3]) <<< 24);
        grp_y = 56'(p_q[4]) <<< 24;
        sum = ROLL_NEG[sub_q[1:0]] ? -grp_r : grp_r;
        sum = PITCH_NEG[sub_q[1:0]] ? sum - grp_p : sum + grp_p;
        sum = YAW_NEG[sub_q[1:0]] ? sum - grp_y : sum + grp_y;
        tmp = (sum + 56'sd8388608) >>> 24;
        cmd = 32'(tmp);
        mul_ld = '{ld: 1'b1, a: 56'(cmd), b: 24'(og_q), n: 5'd10};
        state_d = S_CMD;
      end
      S_CMD: begin
        if (mul_idle) begin
          mot_d[sub_q[1:0]] = sat32(macc_q);
          if (sub_q != 3'd3) begin
            sub_d = nxt;
            state_d = S_SUM;
          end else begin
            sub_d = 3'd0;
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!m_tvalid_q || m_axis_tready) begin
          od_d = {pitch_q, roll_q, mot_q[3], mot_q[2], mot_q[1], mot_q[0]};
          m_tvalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sub_q <= '0;
      ph_q <= 1'b0;
      m_tvalid_q <= 1'b0;
      g_q <= RST_BLEND_GAIN;
      gss_q <= RST_GYRO_SCALE;
      og_q <= RST_OUT_GAIN;
      roll_q <= '0;
      pitch_q <= '0;
      mcnt_q <= '0;
      sb_q <= '0;
      zero_q <= 1'b0;
      cit_q <= '0;
    end else begin
      state_q <= state_d;
      sub_q <= sub_d;
      ph_q <= ph_d;
      m_tvalid_q <= m_tvalid_d;
      g_q <= g_d;
      gss_q <= gss_d;
      og_q <= og_d;
      roll_q <= roll_d;
      pitch_q <= pitch_d;
      mcnt_q <= mcnt_d;
      sb_q <= sb_d;
      zero_q <= zero_d;
      cit_q <= cit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d;
    ay_q <= ay_d;
    az_q <= az_d;
    rx_q <= rx_d;
    ry_q <= ry_d;
    rz_q <= rz_d;
    sq_q <= sq_d;
    sv_q <= sv_d;
    sr_q <= sr_d;
    cx_q <= cx_d;
    cy_q <= cy_d;
    cz_q <= cz_d;
    accr_q <= accr_d;
    accp_q <= accp_d;
    p_q <= p_d;
    mot_q <= mot_d;
    od_q <= od_d;
    ma_q <= ma_d;
    mb_q <= mb_d;
    macc_q <= macc_d;
  end

  `ALM_ASSERT(a_ready_mul_idle, clk_i, rst_ni, s_axis_tready |-> mul_idle)
  `ALM_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, state_q == S_SQY && mcnt_q == 5'd16)
  `ALM_ASSERT(a_mul_no_reload, clk_i, rst_ni, mul_ld.ld |-> mul_idle)
  `ALM_ASSERT(a_out_from_last, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(state_q == S_OUT))
  `ALM_ASSERT(a_sqrt_bit, clk_i, rst_ni, $onehot0(sb_q))

endmodule
